/* hw/rtl/http_chunked_body_decoder_assert.svh */
// ----------------------------------------------------------------------------
// Chunked body decoder assertion macros
// Shared concurrent assertion forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef HTTP_CHUNKED_BODY_DECODER_ASSERT_SVH
`define HTTP_CHUNKED_BODY_DECODER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define HCBD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("chunked decoder check failed");

// Next-cycle implication, disabled while reset is asserted.
`define HCBD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("chunked decoder check failed");

`endif

/* hw/rtl/hcbd_pkg.sv */
// ----------------------------------------------------------------------------
// Chunked body decoder package
// Shared types, codes and field layout for the chunked body decoder.
// ----------------------------------------------------------------------------
package hcbd_pkg;

    // Default width of the chunk size and remaining-byte registers.
    localparam int LENGTH_BITS_DEF = 32;

    // Stream layout.
    localparam int BYTE_W     = 8;
    localparam int ERR_W      = 3;
    localparam int S_TDATA_W  = 8;
    localparam int M_TDATA_W  = 16;
    localparam int M_PAD_W    = M_TDATA_W - BYTE_W - 1 - ERR_W;

    localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
    localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
    localparam logic [BYTE_W-1:0] CH_VT    = 8'h0B;
    localparam logic [BYTE_W-1:0] CH_FF    = 8'h0C;
    localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [BYTE_W-1:0] CH_NINE  = 8'h39;
    localparam logic [BYTE_W-1:0] CH_LC_A  = 8'h61;
    localparam logic [BYTE_W-1:0] CH_LC_F  = 8'h66;
    localparam logic [BYTE_W-1:0] CH_UC_A  = 8'h41;
    localparam logic [BYTE_W-1:0] CH_UC_F  = 8'h46;
    localparam logic [BYTE_W-1:0] CH_LC_X  = 8'h78;
    localparam logic [BYTE_W-1:0] CH_UC_X  = 8'h58;

    typedef enum logic [2:0] {
        PH_BLANK    = 3'd0,
        PH_DIGITS   = 3'd1,
        PH_REST     = 3'd2,
        PH_REST_BAD = 3'd3,
        PH_DATA     = 3'd4,
        PH_TAIL     = 3'd5,
        PH_DONE     = 3'd6,
        PH_ERROR    = 3'd7
    } t_phase;

    typedef enum logic [ERR_W-1:0] {
        ERR_NONE      = 3'd0,
        ERR_EARLY_END = 3'd1,
        ERR_NO_DIGITS = 3'd2,
        ERR_BAD_TAIL  = 3'd3,
        ERR_OVERFLOW  = 3'd4
    } t_err;

    typedef enum logic [1:0] {
        PFX_NONE  = 2'd0,
        PFX_ZERO  = 2'd1,
        PFX_X     = 2'd2,
        PFX_DIGIT = 2'd3
    } t_prefix;

    // Classification of one received byte.
    typedef struct packed {
        logic       is_cr;
        logic       is_lf;
        logic       is_blank;
        logic       is_hex;
        logic       is_zero;
        logic       is_x;
        logic [3:0] hex_val;
    } t_char_class;

    // One decoded result.
    typedef struct packed {
        logic              payload_valid;
        logic [BYTE_W-1:0] payload_byte;
        logic              finished;
        t_err              error_code;
    } t_result;

endpackage

/* hw/rtl/hcbd_classify.sv */
// ----------------------------------------------------------------------------
// Chunked body decoder byte classifier
// Flags line-end, blank and hex characters and gives the hex digit value.
// ----------------------------------------------------------------------------
module hcbd_classify (
    input  logic [hcbd_pkg::BYTE_W-1:0] i_byte,
    output hcbd_pkg::t_char_class       o_class
);
    import hcbd_pkg::*;

    logic w_dec;
    logic w_lc;
    logic w_uc;

    assign w_dec = (i_byte >= CH_ZERO) && (i_byte <= CH_NINE);
    assign w_lc  = (i_byte >= CH_LC_A) && (i_byte <= CH_LC_F);
    assign w_uc  = (i_byte >= CH_UC_A) && (i_byte <= CH_UC_F);

    always_comb begin
        o_class.is_cr    = (i_byte == CH_CR);
        o_class.is_lf    = (i_byte == CH_LF);
        o_class.is_blank = (i_byte == CH_SPACE) || (i_byte == CH_TAB) ||
                           (i_byte == CH_VT) || (i_byte == CH_FF);
        o_class.is_hex   = w_dec || w_lc || w_uc;
        o_class.is_zero  = (i_byte == CH_ZERO);
        o_class.is_x     = (i_byte == CH_LC_X) || (i_byte == CH_UC_X);
        // Letters a-f and A-F share the low nibble 1..6; add 9 to get 10..15.
        if (w_dec) begin
            o_class.hex_val = i_byte[3:0];
        end else if (w_lc || w_uc) begin
            o_class.hex_val = i_byte[3:0] + 4'd9;
        end else begin
            o_class.hex_val = 4'd0;
        end
    end

endmodule

/* hw/rtl/hcbd_fsm.sv */
// ----------------------------------------------------------------------------
// Chunked body decoder parse state machine
// Holds the parse state and computes the result for each accepted byte.
// ----------------------------------------------------------------------------
module hcbd_fsm #(
    parameter int LENGTH_BITS = hcbd_pkg::LENGTH_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_accept,
    input  logic [hcbd_pkg::BYTE_W-1:0] i_byte,
    input  logic                        i_eos,
    input  hcbd_pkg::t_char_class       i_class,
    output hcbd_pkg::t_result           o_result
);
    import hcbd_pkg::*;

    t_phase                 r_phase,  n_phase;
    logic [LENGTH_BITS-1:0] r_acc,    n_acc;
    t_prefix                r_prefix, n_prefix;
    logic [LENGTH_BITS-1:0] r_left,   n_left;
    t_err                   r_status, n_status;

    logic w_overflow;
    logic w_acc_zero;
    logic w_terminal;
    logic w_last_data;

    // Another digit would push a set bit out of the top nibble.
    assign w_overflow  = (r_acc[LENGTH_BITS-1 -: 4] != 4'd0);
    assign w_acc_zero  = (r_acc == '0);
    assign w_terminal  = (r_phase == PH_DONE) || (r_phase == PH_ERROR);
    assign w_last_data = (r_left == LENGTH_BITS'(1));

    // Next phase.
    always_comb begin
        n_phase = r_phase;
        if (w_terminal) begin
            n_phase = r_phase;
        end else if (i_eos) begin
            n_phase = PH_ERROR;
        end else begin
            unique case (r_phase)
                PH_DATA: begin
                    if (w_last_data) n_phase = PH_TAIL;
                end
                PH_TAIL: begin
                    if (i_class.is_lf) begin
                        n_phase = w_acc_zero ? PH_DONE : PH_BLANK;
                    end else if (!i_class.is_cr) begin
                        n_phase = PH_ERROR;
                    end
                end
                PH_BLANK: begin
                    priority if (i_class.is_cr || i_class.is_blank) begin
                        n_phase = PH_BLANK;
                    end else if (i_class.is_lf) begin
                        n_phase = PH_ERROR;
                    end else if (i_class.is_hex) begin
                        n_phase = PH_DIGITS;
                    end else begin
                        n_phase = PH_REST_BAD;
                    end
                end
                PH_DIGITS: begin
                    priority if (i_class.is_cr) begin
                        n_phase = PH_DIGITS;
                    end else if (i_class.is_lf) begin
                        n_phase = w_acc_zero ? PH_TAIL : PH_DATA;
                    end else if ((r_prefix == PFX_ZERO) && i_class.is_x) begin
                        n_phase = PH_DIGITS;
                    end else if (i_class.is_hex) begin
                        n_phase = w_overflow ? PH_ERROR : PH_DIGITS;
                    end else begin
                        n_phase = PH_REST;
                    end
                end
                PH_REST: begin
                    if (i_class.is_lf) n_phase = w_acc_zero ? PH_TAIL : PH_DATA;
                end
                PH_REST_BAD: begin
                    if (i_class.is_lf) n_phase = PH_ERROR;
                end
                PH_DONE, PH_ERROR: begin
                    n_phase = r_phase;
                end
            endcase
        end
    end

    // Datapath updates and the result of this byte.
    always_comb begin
        n_acc    = r_acc;
        n_prefix = r_prefix;
        n_left   = r_left;
        n_status = r_status;
        o_result.payload_valid = 1'b0;
        o_result.payload_byte  = '0;
        if (!w_terminal) begin
            if (i_eos) begin
                n_status = ERR_EARLY_END;
            end else begin
                unique case (r_phase)
                    PH_DATA: begin
                        o_result.payload_valid = 1'b1;
                        o_result.payload_byte  = i_byte;
                        n_left = r_left - LENGTH_BITS'(1);
                    end
                    PH_TAIL: begin
                        if (i_class.is_lf) begin
                            if (!w_acc_zero) begin
                                n_acc    = '0;
                                n_prefix = PFX_NONE;
                            end
                        end else if (!i_class.is_cr) begin
                            n_status = ERR_BAD_TAIL;
                        end
                    end
                    PH_BLANK: begin
                        priority if (i_class.is_cr || i_class.is_blank) begin
                            n_acc = r_acc;
                        end else if (i_class.is_lf) begin
                            n_status = ERR_NO_DIGITS;
                        end else if (i_class.is_hex) begin
                            n_acc    = LENGTH_BITS'(i_class.hex_val);
                            n_prefix = i_class.is_zero ? PFX_ZERO : PFX_DIGIT;
                        end else begin
                            n_acc = r_acc;
                        end
                    end
                    PH_DIGITS: begin
                        priority if (i_class.is_cr) begin
                            n_acc = r_acc;
                        end else if (i_class.is_lf) begin
                            n_left = r_acc;
                        end else if ((r_prefix == PFX_ZERO) && i_class.is_x) begin
                            n_prefix = PFX_X;
                        end else if (i_class.is_hex) begin
                            n_prefix = PFX_DIGIT;
                            if (w_overflow) begin
                                n_status = ERR_OVERFLOW;
                            end else begin
                                n_acc = {r_acc[LENGTH_BITS-5:0], i_class.hex_val};
                            end
                        end else begin
                            n_acc = r_acc;
                        end
                    end
                    PH_REST: begin
                        if (i_class.is_lf) n_left = r_acc;
                    end
                    PH_REST_BAD: begin
                        if (i_class.is_lf) n_status = ERR_NO_DIGITS;
                    end
                    PH_DONE, PH_ERROR: begin
                        n_acc = r_acc;
                    end
                endcase
            end
        end
        o_result.finished   = (n_phase == PH_DONE);
        o_result.error_code = n_status;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_BLANK;
            r_acc    <= '0;
            r_prefix <= PFX_NONE;
            r_left   <= '0;
            r_status <= ERR_NONE;
        end else if (i_accept) begin
            r_phase  <= n_phase;
            r_acc    <= n_acc;
            r_prefix <= n_prefix;
            r_left   <= n_left;
            r_status <= n_status;
        end
    end

endmodule

/* hw/rtl/hcbd_out_reg.sv */
// ----------------------------------------------------------------------------
// Chunked body decoder result register
// Holds one result until the downstream side takes it.
// ----------------------------------------------------------------------------
module hcbd_out_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  hcbd_pkg::t_result i_result,
    input  logic              i_take,
    output logic              o_valid,
    output logic              o_room,
    output hcbd_pkg::t_result o_result
);
    import hcbd_pkg::*;

    logic    r_valid;
    t_result r_result;

    // Room for a new result when empty or when the held one leaves now.
    assign o_room   = !r_valid || i_take;
    assign o_valid  = r_valid;
    assign o_result = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

endmodule

/* hw/rtl/http_chunked_body_decoder.sv */
// Output: the result for an accepted byte is registered and appears on the master side in the cycle after.
// Throughput: one byte per cycle; the single result register is refilled in the
// same cycle its transaction completes, so only downstream back-pressure slows input.
// Reset: synchronous active-low i_rst_n returns the parser to the start of a size
// line, clears the size and remaining-byte registers and empties the result register.
// ----------------------------------------------------------------------------
// HTTP chunked body decoder
// Parses chunk size lines and forwards exactly the announced payload bytes.
// ----------------------------------------------------------------------------
module http_chunked_body_decoder #(
    parameter int LENGTH_BITS = hcbd_pkg::LENGTH_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // Bits from the lowest: in_byte[7:0].
    input  logic [hcbd_pkg::S_TDATA_W-1:0] s_axis_tdata,
    // Bits from the lowest: end_of_stream[0].
    input  logic                           s_axis_tuser,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // Bits from the lowest: payload_byte[7:0], finished[8], error_code[11:9],
    // zero padding[15:12].
    output logic [hcbd_pkg::M_TDATA_W-1:0] m_axis_tdata,
    // Bits from the lowest: payload_valid[0].
    output logic                           m_axis_tuser
);
    import hcbd_pkg::*;

    // Every input transaction produces exactly one output transaction. An input
    // byte is taken whenever the result register is empty or is being drained in
    // the same cycle, so the decoder never waits on its own state.
    logic        w_accept;
    logic        w_room;
    logic        w_take;
    t_char_class w_class;
    t_result     w_result;
    t_result     w_held;

    assign w_take        = m_axis_tvalid && m_axis_tready;
    assign s_axis_tready = w_room;
    assign w_accept      = s_axis_tvalid && w_room;

    // Character classification is purely combinational on the incoming byte.
    hcbd_classify u_classify (
        .i_byte  (s_axis_tdata),
        .o_class (w_class)
    );

    // The parser updates its state only on an accepted transaction. The result
    // it computes for that byte goes straight into the result register.
    hcbd_fsm #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_fsm (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_byte   (s_axis_tdata),
        .i_eos    (s_axis_tuser),
        .i_class  (w_class),
        .o_result (w_result)
    );

    hcbd_out_reg u_out_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (w_accept),
        .i_result (w_result),
        .i_take   (w_take),
        .o_valid  (m_axis_tvalid),
        .o_room   (w_room),
        .o_result (w_held)
    );

    // Pack the held result onto the master stream.
    assign m_axis_tdata = {{M_PAD_W{1'b0}}, w_held.error_code, w_held.finished,
                           w_held.payload_byte};
    assign m_axis_tuser = w_held.payload_valid;

endmodule

/* hw/rtl/hcbd_checker.sv */
// ----------------------------------------------------------------------------
// Chunked body decoder port checker
// Watches the decoder ports for stalls, rate and result consistency.
// ----------------------------------------------------------------------------
`include "http_chunked_body_decoder_assert.svh"

module hcbd_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           s_axis_tvalid,
    input logic                           s_axis_tready,
    input logic [hcbd_pkg::S_TDATA_W-1:0] s_axis_tdata,
    input logic                           s_axis_tuser,
    input logic                           m_axis_tvalid,
    input logic                           m_axis_tready,
    input logic [hcbd_pkg::M_TDATA_W-1:0] m_axis_tdata,
    input logic                           m_axis_tuser
);
    import hcbd_pkg::*;

    logic             w_fin;
    logic [ERR_W-1:0] w_err;

    assign w_fin = m_axis_tdata[BYTE_W];
    assign w_err = m_axis_tdata[BYTE_W+1 +: ERR_W];

    // A stalled result holds its contents.
    `HCBD_ASSERT_NEXT(a_stall_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    // With the result register empty the decoder must take input.
    `HCBD_ASSERT_NOW(a_ready_when_empty, i_clk, i_rst_n, !m_axis_tvalid, s_axis_tready)
    // Each accepted byte shows up as a result in the next cycle.
    `HCBD_ASSERT_NEXT(a_result_follows, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, m_axis_tvalid)
    // A forwarded payload byte never coexists with an error or the finished flag.
    `HCBD_ASSERT_NOW(a_payload_clean, i_clk, i_rst_n, m_axis_tvalid && m_axis_tuser, (w_err == ERR_NONE) && !w_fin)

endmodule

bind http_chunked_body_decoder hcbd_checker u_hcbd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

/* test/tb_http_chunked_body_decoder.sv */
// ----------------------------------------------------------------------------
// Testbench for the HTTP chunked body decoder
// Streams a chunked body into the decoder one byte per transaction. Each byte
// runs through a local decoder model when it is accepted. The result returned
// for it is checked against the model, field by field, in order.
// ----------------------------------------------------------------------------
module tb_http_chunked_body_decoder;
    import hcbd_pkg::*;

    localparam int LENGTH_BITS  = LENGTH_BITS_DEF;
    localparam int BODY_TARGET  = 1550;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 16;
    localparam int N_DIRECTED   = 24;

    // Characters that the package does not name.
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_SEMI    = 8'h3B;
    localparam logic [7:0] CH_DIGIT_1 = 8'h31;
    localparam logic [7:0] CH_DIGIT_3 = 8'h33;
    localparam logic [7:0] CH_LC_G    = 8'h67;
    localparam logic [7:0] CH_LC_Z    = 8'h7A;
    localparam logic [7:0] CH_UC_Z    = 8'h5A;

    // A result with nothing forwarded, not finished and no error.
    localparam t_result QUIET = '{1'b0, 8'h00, 1'b0, ERR_NONE};

    // The ways the body stream can be closed. Only one of them is reached in a
    // run because the decoder never leaves its finished or error state.
    typedef enum logic [2:0] {
        END_CLEAN,
        END_PREFIX_ONLY,
        END_EOS_DATA,
        END_EOS_TAIL,
        END_NO_DIGITS,
        END_BAD_TAIL,
        END_OVERFLOW
    } t_ending;

    // One byte of the body stream. When "typed" is set, "want" holds a result
    // written out by hand that replaces the model's result for that byte.
    typedef struct packed {
        logic [7:0] data;
        logic       eos;
        logic       typed;
        t_result    want;
    } t_body_item;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata;
    logic                 s_axis_tuser;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [M_TDATA_W-1:0] m_axis_tdata;
    logic                 m_axis_tuser;

    // Whole stimulus stream, built before reset is released.
    t_body_item body_bytes[$];
    // Results that the model has produced and the decoder still owes.
    t_result    decoded_q[$];

    int unsigned fail_count  = 0;
    int unsigned cycle_count = 0;
    int unsigned taken_count = 0;

    // State of the local decoder model.
    t_phase                 dec_phase;
    logic [LENGTH_BITS-1:0] size_acc;
    t_prefix                prefix_seen;
    logic [LENGTH_BITS-1:0] bytes_remaining;
    t_err                   dec_status;

    logic [7:0] blank_chars [4] = '{CH_SPACE, CH_TAB, CH_VT, CH_FF};
    logic [7:0] ext_lead [7]    = '{CH_SEMI, CH_SPACE, CH_LC_G, CH_PLUS, CH_MINUS,
                                    CH_LC_Z, CH_TAB};
    logic [7:0] bad_lead [5]    = '{CH_MINUS, CH_PLUS, CH_SEMI, CH_LC_G, CH_UC_Z};

    // Directed opening. It walks through the blank skipping, the upper case prefix
    // spellings, carriage returns dropped inside a size line, a sign character
    // that ends the digits, leading zeros, an extension that starts with an x
    // after real digits, data bytes at both extremes and an LF used as data,
    // and a chunk end both with and without the carriage return.
    t_body_item directed_rows [N_DIRECTED] = '{
        '{CH_SPACE,   1'b0, 1'b1, QUIET},                          // first byte after reset
        '{CH_TAB,     1'b0, 1'b0, QUIET},
        '{CH_ZERO,    1'b0, 1'b0, QUIET},
        '{CH_UC_X,    1'b0, 1'b0, QUIET},                          // upper case prefix
        '{CH_ZERO,    1'b0, 1'b0, QUIET},
        '{CH_CR,      1'b0, 1'b0, QUIET},                          // dropped among digits
        '{CH_DIGIT_3, 1'b0, 1'b0, QUIET},
        '{CH_PLUS,    1'b0, 1'b0, QUIET},                          // sign ends the digits
        '{CH_CR,      1'b0, 1'b0, QUIET},
        '{CH_LF,      1'b0, 1'b0, QUIET},                          // size is three
        '{8'h00,      1'b0, 1'b1, '{1'b1, 8'h00, 1'b0, ERR_NONE}},
        '{8'hFF,      1'b0, 1'b1, '{1'b1, 8'hFF, 1'b0, ERR_NONE}},
        '{CH_LF,      1'b0, 1'b1, '{1'b1, CH_LF, 1'b0, ERR_NONE}},
        '{CH_CR,      1'b0, 1'b0, QUIET},
        '{CH_LF,      1'b0, 1'b0, QUIET},
        '{CH_VT,      1'b0, 1'b0, QUIET},
        '{CH_FF,      1'b0, 1'b0, QUIET},
        '{CH_ZERO,    1'b0, 1'b0, QUIET},
        '{CH_ZERO,    1'b0, 1'b0, QUIET},
        '{CH_DIGIT_1, 1'b0, 1'b0, QUIET},
        '{CH_LC_X,    1'b0, 1'b0, QUIET},                          // x after digits is not a prefix
        '{CH_LF,      1'b0, 1'b0, QUIET},
        '{8'h5A,      1'b0, 1'b0, QUIET},
        '{CH_LF,      1'b0, 1'b0, QUIET}                           // chunk end without CR
    };

    http_chunked_body_decoder #(
        .LENGTH_BITS(LENGTH_BITS)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // ------------------------------------------------------------------------
    // Decoder model
    // ------------------------------------------------------------------------

    // Value of a hex digit character, or -1 for any other byte.
    function automatic int hex_digit(input logic [7:0] c);
        if (c >= CH_ZERO && c <= CH_NINE) return int'(c - CH_ZERO);
        if (c >= CH_LC_A && c <= CH_LC_F) return int'(c - CH_LC_A) + 10;
        if (c >= CH_UC_A && c <= CH_UC_F) return int'(c - CH_UC_A) + 10;
        return -1;
    endfunction

    function automatic void decode_fail(input t_err code);
        dec_status = code;
        dec_phase  = PH_ERROR;
    endfunction

    // LF at the end of a size line: a zero size goes straight to the final
    // line end, anything else opens the data part of the chunk.
    function automatic void close_size_line();
        if (size_acc == '0) begin
            dec_phase = PH_TAIL;
        end else begin
            bytes_remaining = size_acc;
            dec_phase       = PH_DATA;
        end
    endfunction

    // Advances the model by one accepted byte and returns the result it owes.
    function automatic t_result decode_byte(input logic [7:0] c, input logic eos);
        t_result r;
        int      hv;
        r  = QUIET;
        hv = hex_digit(c);
        if (dec_phase == PH_DONE || dec_phase == PH_ERROR) begin
            // Terminal: the decoder ignores everything from here on.
        end else if (eos) begin
            decode_fail(ERR_EARLY_END);
        end else if (dec_phase == PH_DATA) begin
            r.payload_valid = 1'b1;
            r.payload_byte  = c;
            bytes_remaining = bytes_remaining - LENGTH_BITS'(1);
            if (bytes_remaining == '0) dec_phase = PH_TAIL;
        end else if (dec_phase == PH_TAIL) begin
            if (c == CH_LF) begin
                if (size_acc == '0) begin
                    dec_phase = PH_DONE;
                end else begin
                    dec_phase   = PH_BLANK;
                    size_acc    = '0;
                    prefix_seen = PFX_NONE;
                end
            end else if (c != CH_CR) begin
                decode_fail(ERR_BAD_TAIL);
            end
        end else if (c == CH_CR) begin
            // A carriage return anywhere in a size line is simply dropped.
        end else if (dec_phase == PH_BLANK) begin
            if (c == CH_LF) begin
                decode_fail(ERR_NO_DIGITS);
            end else if (c == CH_SPACE || c == CH_TAB || c == CH_VT || c == CH_FF) begin
                // Leading blanks are skipped.
            end else if (hv >= 0) begin
                size_acc    = LENGTH_BITS'(hv);
                prefix_seen = (c == CH_ZERO) ? PFX_ZERO : PFX_DIGIT;
                dec_phase   = PH_DIGITS;
            end else begin
                dec_phase = PH_REST_BAD;
            end
        end else if (dec_phase == PH_DIGITS) begin
            if (c == CH_LF) begin
                close_size_line();
            end else if (prefix_seen == PFX_ZERO && (c == CH_LC_X || c == CH_UC_X)) begin
                prefix_seen = PFX_X;
            end else if (hv >= 0) begin
                prefix_seen = PFX_DIGIT;
                // One more digit must not push a set bit out of the register.
                if (size_acc[LENGTH_BITS-1 -: 4] != 4'h0)
                    decode_fail(ERR_OVERFLOW);
                else
                    size_acc = {size_acc[LENGTH_BITS-5:0], 4'(hv)};
            end else begin
                dec_phase = PH_REST;
            end
        end else if (dec_phase == PH_REST) begin
            if (c == CH_LF) close_size_line();
        end else begin
            // The line had no digits at all; its LF is the error.
            if (c == CH_LF) decode_fail(ERR_NO_DIGITS);
        end
        r.finished   = (dec_phase == PH_DONE);
        r.error_code = dec_status;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus generation
    // ------------------------------------------------------------------------

    task automatic add_byte(input logic [7:0] b, input logic eos);
        body_bytes.push_back('{b, eos, 1'b0, QUIET});
    endtask

    // A size line byte, sometimes followed by a stray carriage return.
    task automatic add_line_byte(input logic [7:0] b);
        add_byte(b, 1'b0);
        if ($urandom_range(0, 7) == 0) add_byte(CH_CR, 1'b0);
    endtask

    function automatic logic [7:0] hex_char(input int unsigned nib);
        if (nib < 10) return CH_ZERO + 8'(nib);
        return ($urandom_range(0, 1) ? CH_LC_A : CH_UC_A) + 8'(nib - 10);
    endfunction

    function automatic logic [7:0] non_lf_byte();
        logic [7:0] c;
        c = 8'($urandom_range(0, 255));
        while (c == CH_LF) c = 8'($urandom_range(0, 255));
        return c;
    endfunction

    // Extension text after the digits, ignored by the decoder up to the LF.
    task automatic add_extension();
        add_line_byte(ext_lead[$urandom_range(0, 6)]);
        repeat ($urandom_range(0, 5)) add_line_byte(non_lf_byte());
    endtask

    task automatic add_size_line(input int unsigned size);
        int unsigned nib_count;
        int unsigned zeros;
        repeat ($urandom_range(0, 2)) add_line_byte(blank_chars[$urandom_range(0, 3)]);
        if ($urandom_range(0, 3) == 0) begin
            add_line_byte(CH_ZERO);
            add_line_byte($urandom_range(0, 1) ? CH_LC_X : CH_UC_X);
        end
        // Now and then at least as many leading zeros as the register has digits.
        zeros = ($urandom_range(0, 19) == 0) ? $urandom_range(8, 20) : $urandom_range(0, 2);
        repeat (zeros) add_line_byte(CH_ZERO);
        nib_count = 1;
        while ((size >> (4 * nib_count)) != 0) nib_count++;
        for (int i = int'(nib_count) - 1; i >= 0; i--)
            add_line_byte(hex_char((size >> (4 * i)) & 4'hF));
        if ($urandom_range(0, 2) == 0) add_extension();
        if ($urandom_range(0, 1)) add_byte(CH_CR, 1'b0);
        add_byte(CH_LF, 1'b0);
    endtask

    // Line end after the data: up to two carriage returns, then LF.
    task automatic add_line_end();
        repeat ($urandom_range(0, 2)) add_byte(CH_CR, 1'b0);
        add_byte(CH_LF, 1'b0);
    endtask

    task automatic add_chunk_head(input int unsigned size);
        add_size_line(size);
        repeat (size) add_byte(8'($urandom_range(0, 255)), 1'b0);
    endtask

    function automatic int unsigned chunk_size();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(17, 80) : $urandom_range(1, 16);
    endfunction

    // Closes the stream in one of the ways the decoder must handle, then sends
    // a stretch of bytes and end-of-stream flags that it must ignore.
    task automatic add_ending();
        t_ending     how;
        int unsigned size;
        logic [7:0]  c;
        how  = t_ending'($urandom_range(0, 6));
        size = chunk_size() + 1;
        case (how)
            END_CLEAN: begin
                add_size_line(0);
                add_line_end();
            end
            END_PREFIX_ONLY: begin
                // A 0x prefix with no digits after it reads as size zero.
                add_line_byte(CH_ZERO);
                add_line_byte($urandom_range(0, 1) ? CH_LC_X : CH_UC_X);
                add_extension();
                add_byte(CH_LF, 1'b0);
                add_line_end();
            end
            END_EOS_DATA: begin
                add_size_line(size);
                repeat ($urandom_range(0, size - 1)) add_byte(8'($urandom_range(0, 255)), 1'b0);
                add_byte(8'($urandom_range(0, 255)), 1'b1);
            end
            END_EOS_TAIL: begin
                // The stream closes inside the line end of the final chunk.
                add_size_line(0);
                if ($urandom_range(0, 1)) add_byte(CH_CR, 1'b0);
                add_byte(8'($urandom_range(0, 255)), 1'b1);
            end
            END_NO_DIGITS: begin
                repeat ($urandom_range(0, 2)) add_line_byte(blank_chars[$urandom_range(0, 3)]);
                if ($urandom_range(0, 1)) begin
                    add_line_byte(bad_lead[$urandom_range(0, 4)]);
                    repeat ($urandom_range(0, 4)) add_line_byte(non_lf_byte());
                end
                add_byte(CH_LF, 1'b0);
            end
            END_BAD_TAIL: begin
                add_chunk_head(size);
                if ($urandom_range(0, 1)) add_byte(CH_CR, 1'b0);
                c = 8'($urandom_range(0, 255));
                while (c == CH_CR || c == CH_LF) c = 8'($urandom_range(0, 255));
                add_byte(c, 1'b0);
            end
            default: begin
                // Nine significant digits cannot fit in 32 bits; the ninth fails.
                add_line_byte(hex_char($urandom_range(1, 15)));
                repeat (8) add_line_byte(hex_char($urandom_range(0, 15)));
            end
        endcase
        repeat ($urandom_range(10, 30))
            add_byte(8'($urandom_range(0, 255)), $urandom_range(0, 2) == 0);
        add_byte(8'($urandom_range(0, 255)), 1'b1);
    endtask

    // Idle cycles before a transaction, with calm stretches where there are none.
    function automatic int unsigned idle_cycles(input int unsigned n);
        if ((n / 128) % 3 == 1) return 0;
        return $urandom_range(0, 7);
    endfunction

    // ------------------------------------------------------------------------
    // Checking. Both handshakes are sampled at the rising edge. The result
    // check comes first, so a result always meets an older expectation.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (decoded_q.size() == 0) begin
                    $error("result transaction with no expectation waiting");
                    fail_count++;
                end else begin
                    want = decoded_q.pop_front();
                    if (m_axis_tuser !== want.payload_valid) begin
                        $error("payload_valid: expected %0d, got %0d",
                               want.payload_valid, m_axis_tuser);
                        fail_count++;
                    end
                    if (m_axis_tdata[7:0] !== want.payload_byte) begin
                        $error("payload_byte: expected 0x%02h, got 0x%02h",
                               want.payload_byte, m_axis_tdata[7:0]);
                        fail_count++;
                    end
                    if (m_axis_tdata[8] !== want.finished) begin
                        $error("finished: expected %0d, got %0d",
                               want.finished, m_axis_tdata[8]);
                        fail_count++;
                    end
                    if (m_axis_tdata[11:9] !== want.error_code) begin
                        $error("error_code: expected %0d, got %0d",
                               want.error_code, m_axis_tdata[11:9]);
                        fail_count++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                want = decode_byte(body_bytes[taken_count].data, body_bytes[taken_count].eos);
                if (body_bytes[taken_count].typed) want = body_bytes[taken_count].want;
                decoded_q.push_back(want);
                taken_count++;
            end
        end
    end

    // Watchdog: far beyond the slowest correct run, where every transaction
    // sees the longest gap on the input and the longest stall on the output.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb_http_chunked_body_decoder failed");
            $finish;
        end
    end

    // Result side: holds ready low for idle_cycles() before each transaction.
    initial begin
        int unsigned results_seen;
        results_seen  = 0;
        m_axis_tready = 1'b0;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            repeat (idle_cycles(results_seen)) begin
                m_axis_tready = 1'b0;
                @(negedge i_clk);
            end
            m_axis_tready = 1'b1;
            @(posedge i_clk);
            while (!m_axis_tvalid) @(posedge i_clk);
            results_seen++;
            @(negedge i_clk);
        end
    end

    // Byte side: builds the stream, releases reset and sends every byte.
    initial begin
        int unsigned half_way;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 1'b0;
        i_rst_n       = 1'b0;

        dec_phase       = PH_BLANK;
        size_acc        = '0;
        prefix_seen     = PFX_NONE;
        bytes_remaining = '0;
        dec_status      = ERR_NONE;

        foreach (directed_rows[i]) body_bytes.push_back(directed_rows[i]);
        // The random part is made of well-formed chunks with random decoration.
        while (body_bytes.size() < BODY_TARGET) begin
            add_chunk_head(chunk_size());
            add_line_end();
        end
        add_ending();
        half_way = body_bytes.size() / 2;

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        for (int unsigned idx = 0; idx < body_bytes.size(); idx++) begin
            repeat (idle_cycles(idx)) begin
                s_axis_tvalid = 1'b0;
                @(negedge i_clk);
            end
            // Hold off until the decoder has returned every owed result, once
            // after the directed opening and once in the middle of the run.
            if (idx == N_DIRECTED || idx == half_way) begin
                s_axis_tvalid = 1'b0;
                while (decoded_q.size() != 0) @(negedge i_clk);
            end
            s_axis_tvalid = 1'b1;
            s_axis_tdata  = body_bytes[idx].data;
            s_axis_tuser  = body_bytes[idx].eos;
            @(posedge i_clk);
            while (!s_axis_tready) @(posedge i_clk);
            @(negedge i_clk);
        end
        s_axis_tvalid = 1'b0;

        while (decoded_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0)
            $display("tb_http_chunked_body_decoder passed");
        else
            $display("tb_http_chunked_body_decoder failed");
        $finish;
    end

endmodule

/* filelist.f */
+incdir+hw/rtl
hw/rtl/hcbd_pkg.sv
hw/rtl/hcbd_classify.sv
hw/rtl/hcbd_fsm.sv
hw/rtl/hcbd_out_reg.sv
hw/rtl/http_chunked_body_decoder.sv
hw/rtl/hcbd_checker.sv
test/tb_http_chunked_body_decoder.sv
